@@ rtl/cst_pkg.sv @@
// Shared types, token kinds and scanner modes for the token scanner.
package cst_pkg;

    localparam int MAX_RESULTS = 3;

    typedef enum logic [4:0] {
        TK_END    = 5'd0,
        TK_IDENT  = 5'd1,
        TK_IF     = 5'd2,
        TK_WHILE  = 5'd3,
        TK_INT    = 5'd4,
        TK_FLOAT  = 5'd5,
        TK_STRING = 5'd6,
        TK_CHAR   = 5'd7,
        TK_LPAREN = 5'd8,
        TK_RPAREN = 5'd9,
        TK_LBRACE = 5'd10,
        TK_RBRACE = 5'd11,
        TK_EQ     = 5'd12,
        TK_NE     = 5'd13,
        TK_LE     = 5'd14,
        TK_LT     = 5'd15,
        TK_GE     = 5'd16,
        TK_GT     = 5'd17,
        TK_OTHER  = 5'd18
    } token_kind_t;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_INT, M_DOT, M_FRAC, M_EXPS, M_EXP, M_HEX, M_SUF,
        M_STR, M_CHR, M_SLASH, M_LINEC, M_BLOCK, M_CMP
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [23:0] start_line;
        logic [15:0] start_column;
        logic [15:0] token_length;
        logic        last_of_run;
    } out_item_t;

    // Per-token kind, a position select and a length select for one result slot.
    typedef struct packed {
        logic        valid;
        token_kind_t kind;
        logic        use_cur;   // position from current counters, else token start
        logic        len_fix;   // 1: fixed length below, else byte count
        logic [1:0]  fixed_len;
    } slot_t;

endpackage

@@ rtl/c_subset_token_scanner_core.sv @@
// Streaming C subset token scanner: top level.
// Results: the tokens for a byte are written into the result queue when that byte is accepted.
// Throughput: one byte per cycle while the eight-entry result queue has room
// for three results; each byte gives 0 to 3 results, drained one per cycle while m_ready is high.
// Reset: synchronous active-low aresetn returns the scanner to line 1,
// column 1 between tokens and empties the result queue; an end mark does the same but keeps the queue.
module c_subset_token_scanner_core #(
    parameter int LINE_BITS   = 24,
    parameter int COLUMN_BITS = 16,
    parameter int LENGTH_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cst_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cst_pkg::out_item_t  m_data
);
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;

    cst_pkg::scan_mode_t mode_reg, mode_next;
    logic [LINE_BITS-1:0]   line_reg, line_next, tline_reg, tline_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next, tcol_reg, tcol_next;
    logic [LENGTH_BITS-1:0] cnt_reg, cnt_next;
    logic [39:0] pre_reg, pre_next;
    logic f_float_reg, f_float_next, f_zero_reg, f_zero_next;
    logic f_esc_reg, f_esc_next, f_star_reg, f_star_next;

    cst_pkg::slot_t slots [cst_pkg::MAX_RESULTS];
    cst_pkg::out_item_t push_item [cst_pkg::MAX_RESULTS];
    logic [1:0] push_count;
    logic       accept, has_room;
    logic [7:0] c;
    logic       eoi;
    // Position snapshot for the slots that use the current position.
    logic [LINE_BITS-1:0]   dot_line;
    logic [COLUMN_BITS-1:0] dot_col;

    assign s_ready = has_room;
    assign accept  = s_valid && s_ready;
    assign c       = s_data.text_byte;
    assign eoi     = s_data.end_of_input;

    function automatic logic is_digit(logic [7:0] x);
        return x >= "0" && x <= "9";
    endfunction
    function automatic logic is_alpha(logic [7:0] x);
        return (x >= "a" && x <= "z") || (x >= "A" && x <= "Z");
    endfunction
    function automatic logic is_xdigit(logic [7:0] x);
        return is_digit(x) || (x >= "a" && x <= "f") || (x >= "A" && x <= "F");
    endfunction
    function automatic logic is_suffix(logic [7:0] x);
        return x == "u" || x == "U" || x == "l" || x == "L" || x == "f" || x == "F";
    endfunction
    function automatic cst_pkg::token_kind_t cmp_kind(logic [7:0] ch, logic dbl);
        case (ch)
            "=":     return dbl ? cst_pkg::TK_EQ : cst_pkg::TK_OTHER;
            "!":     return dbl ? cst_pkg::TK_NE : cst_pkg::TK_OTHER;
            "<":     return dbl ? cst_pkg::TK_LE : cst_pkg::TK_LT;
            default: return dbl ? cst_pkg::TK_GE : cst_pkg::TK_GT;
        endcase
    endfunction

    // Scanner next state and emitted results for one byte.
    always_comb begin
        logic [LINE_BITS-1:0]   l;
        logic [COLUMN_BITS-1:0] col;
        logic [LENGTH_BITS-1:0] n;
        logic [1:0] ns;
        logic       restart, ws, isnl, is_f;
        cst_pkg::token_kind_t ik, nk;
        l = line_reg; col = col_reg; n = cnt_reg; ns = 2'd0;
        restart = 1'b0;
        mode_next = mode_reg; tline_next = tline_reg; tcol_next = tcol_reg;
        pre_next = pre_reg;
        f_float_next = f_float_reg; f_zero_next = f_zero_reg;
        f_esc_next = f_esc_reg; f_star_next = f_star_reg;
        for (int i = 0; i < cst_pkg::MAX_RESULTS; i++) slots[i] = '0;
        dot_line = line_reg; dot_col = col_reg;
        isnl = (c == 8'h0A);
        ws   = (c == " " || c == 8'h09 || c == 8'h0D || isnl);
        is_f = (c == "f" || c == "F");
        ik = cst_pkg::TK_IDENT;
        if (cnt_reg == LENGTH_BITS'(2) && pre_reg == 40'h6966) ik = cst_pkg::TK_IF;
        else if (cnt_reg == LENGTH_BITS'(5) && pre_reg == 40'h7768696C65) ik = cst_pkg::TK_WHILE;
        nk = f_float_reg ? cst_pkg::TK_FLOAT : cst_pkg::TK_INT;

        if (eoi) begin
            unique case (mode_reg)
                cst_pkg::M_IDENT: begin slots[0] = '{1'b1, ik, 1'b0, 1'b0, 2'd0}; ns = 2'd1; end
                cst_pkg::M_INT, cst_pkg::M_FRAC, cst_pkg::M_EXPS, cst_pkg::M_EXP,
                cst_pkg::M_HEX, cst_pkg::M_SUF: begin
                    slots[0] = '{1'b1, nk, 1'b0, 1'b0, 2'd0}; ns = 2'd1;
                end
                cst_pkg::M_DOT: begin
                    slots[0] = '{1'b1, nk, 1'b0, 1'b0, 2'd0};
                    slots[1] = '{1'b1, cst_pkg::TK_OTHER, 1'b1, 1'b1, 2'd1};
                    ns = 2'd2;
                end
                cst_pkg::M_STR: begin slots[0] = '{1'b1, cst_pkg::TK_STRING, 1'b0, 1'b0, 2'd0}; ns = 2'd1; end
                cst_pkg::M_CHR: begin slots[0] = '{1'b1, cst_pkg::TK_CHAR, 1'b0, 1'b0, 2'd0}; ns = 2'd1; end
                cst_pkg::M_SLASH: begin slots[0] = '{1'b1, cst_pkg::TK_OTHER, 1'b0, 1'b1, 2'd1}; ns = 2'd1; end
                cst_pkg::M_CMP: begin
                    slots[0] = '{1'b1, cmp_kind(pre_reg[7:0], 1'b0), 1'b0, 1'b1, 2'd1}; ns = 2'd1;
                end
                default: ;
            endcase
            // End token sits at the current position; after a dot, one column on.
            if (mode_reg == cst_pkg::M_DOT && col_reg < COL_MAX) begin
                dot_col = col_reg + COLUMN_BITS'(1);
            end
            slots[ns] = '{1'b1, cst_pkg::TK_END, 1'b1, 1'b1, 2'd0};
            ns = ns + 2'd1;
            mode_next = cst_pkg::M_IDLE;
            l = LINE_BITS'(1); col = COLUMN_BITS'(1); n = '0;
            tline_next = LINE_BITS'(1); tcol_next = COLUMN_BITS'(1);
            pre_next = '0;
            f_float_next = 1'b0; f_zero_next = 1'b0; f_esc_next = 1'b0; f_star_next = 1'b0;
        end else begin
            logic adv, cnt1, adv_dot;
            adv = 1'b0; cnt1 = 1'b0; adv_dot = 1'b0;
            unique case (mode_reg)
                cst_pkg::M_IDENT: begin
                    if (is_alpha(c) || is_digit(c) || c == "_") begin
                        adv = 1'b1; cnt1 = 1'b1; pre_next = {pre_reg[31:0], c};
                    end else begin
                        slots[0] = '{1'b1, ik, 1'b0, 1'b0, 2'd0}; ns = 2'd1; restart = 1'b1;
                    end
                end
                cst_pkg::M_INT: begin
                    f_zero_next = 1'b0;
                    if (f_zero_reg && (c == "x" || c == "X")) begin
                        adv = 1'b1; cnt1 = 1'b1; mode_next = cst_pkg::M_HEX;
                    end else if (is_digit(c)) begin
                        adv = 1'b1; cnt1 = 1'b1;
                    end else if (c == ".") begin
                        mode_next = cst_pkg::M_DOT;
                    end else if (c == "e" || c == "E") begin
                        adv = 1'b1; cnt1 = 1'b1; f_float_next = 1'b1; mode_next = cst_pkg::M_EXPS;
                    end else if (is_suffix(c)) begin
                        adv = 1'b1; cnt1 = 1'b1; f_float_next = f_float_reg | is_f;
                        mode_next = cst_pkg::M_SUF;
                    end else begin
                        slots[0] = '{1'b1, nk, 1'b0, 1'b0, 2'd0}; ns = 2'd1; restart = 1'b1;
                    end
                end
                cst_pkg::M_DOT: begin
                    if (is_digit(c)) begin
                        adv_dot = 1'b1; adv = 1'b1; cnt1 = 1'b1; f_float_next = 1'b1;
                        mode_next = cst_pkg::M_FRAC;
                    end else begin
                        slots[0] = '{1'b1, nk, 1'b0, 1'b0, 2'd0};
                        slots[1] = '{1'b1, cst_pkg::TK_OTHER, 1'b1, 1'b1, 2'd1};
                        ns = 2'd2; adv_dot = 1'b1; restart = 1'b1;
                    end
                end
                cst_pkg::M_FRAC, cst_pkg::M_EXP, cst_pkg::M_HEX: begin
                    if ((mode_reg == cst_pkg::M_HEX) ? is_xdigit(c) : is_digit(c)) begin
                        adv = 1'b1; cnt1 = 1'b1;
                    end else if (mode_reg == cst_pkg::M_FRAC && (c == "e" || c == "E")) begin
                        adv = 1'b1; cnt1 = 1'b1; f_float_next = 1'b1; mode_next = cst_pkg::M_EXPS;
                    end else if (is_suffix(c)) begin
                        adv = 1'b1; cnt1 = 1'b1; f_float_next = f_float_reg | is_f;
                        mode_next = cst_pkg::M_SUF;
                    end else begin
                        slots[0] = '{1'b1, nk, 1'b0, 1'b0, 2'd0}; ns = 2'd1; restart = 1'b1;
                    end
                end
                cst_pkg::M_EXPS: begin
                    if (c == "+" || c == "-" || is_digit(c)) begin
                        adv = 1'b1; cnt1 = 1'b1; mode_next = cst_pkg::M_EXP;
                    end else if (is_suffix(c)) begin
                        adv = 1'b1; cnt1 = 1'b1; f_float_next = f_float_reg | is_f;
                        mode_next = cst_pkg::M_SUF;
                    end else begin
                        slots[0] = '{1'b1, nk, 1'b0, 1'b0, 2'd0}; ns = 2'd1; restart = 1'b1;
                    end
                end
                cst_pkg::M_SUF: begin
                    if (is_suffix(c)) begin
                        adv = 1'b1; cnt1 = 1'b1; f_float_next = f_float_reg | is_f;
                    end else begin
                        slots[0] = '{1'b1, nk, 1'b0, 1'b0, 2'd0}; ns = 2'd1; restart = 1'b1;
                    end
                end
                cst_pkg::M_STR, cst_pkg::M_CHR: begin
                    adv = 1'b1; cnt1 = 1'b1;
                    if (f_esc_reg) begin
                        f_esc_next = 1'b0;
                    end else if (c == ((mode_reg == cst_pkg::M_STR) ? 8'h22 : 8'h27)) begin
                        slots[0] = '{1'b1, (mode_reg == cst_pkg::M_STR) ? cst_pkg::TK_STRING
                                                                       : cst_pkg::TK_CHAR,
                                     1'b0, 1'b0, 2'd0};
                        ns = 2'd1; mode_next = cst_pkg::M_IDLE;
                    end else if (c == 8'h5C) begin
                        f_esc_next = 1'b1;
                    end
                end
                cst_pkg::M_SLASH: begin
                    if (c == "/") begin
                        adv = 1'b1; mode_next = cst_pkg::M_LINEC;
                    end else if (c == "*") begin
                        adv = 1'b1; f_star_next = 1'b0; mode_next = cst_pkg::M_BLOCK;
                    end else begin
                        slots[0] = '{1'b1, cst_pkg::TK_OTHER, 1'b0, 1'b1, 2'd1}; ns = 2'd1;
                        restart = 1'b1;
                    end
                end
                cst_pkg::M_LINEC: begin
                    if (!isnl) adv = 1'b1;
                    else restart = 1'b1;
                end
                cst_pkg::M_BLOCK: begin
                    adv = 1'b1;
                    if (f_star_reg && c == "/") begin
                        f_float_next = 1'b0; f_zero_next = 1'b0; f_esc_next = 1'b0;
                        f_star_next = 1'b0; mode_next = cst_pkg::M_IDLE;
                    end else begin
                        f_star_next = (c == "*");
                    end
                end
                cst_pkg::M_CMP: begin
                    if (c == "=") begin
                        adv = 1'b1; cnt1 = 1'b1;
                        slots[0] = '{1'b1, cmp_kind(pre_reg[7:0], 1'b1), 1'b0, 1'b1, 2'd2};
                        ns = 2'd1; mode_next = cst_pkg::M_IDLE;
                    end else begin
                        slots[0] = '{1'b1, cmp_kind(pre_reg[7:0], 1'b0), 1'b0, 1'b1, 2'd1};
                        ns = 2'd1; restart = 1'b1;
                    end
                end
                default: restart = 1'b1;
            endcase

            // A pending dot moves the column by one before the current byte.
            if (adv_dot) begin
                if (col < COL_MAX) col = col + COLUMN_BITS'(1);
                if (mode_next == cst_pkg::M_FRAC && n < LEN_MAX) n = n + LENGTH_BITS'(1);
            end
            if (adv) begin
                if (isnl) begin
                    if (l < LINE_MAX) l = l + LINE_BITS'(1);
                    col = COLUMN_BITS'(1);
                end else if (col < COL_MAX) begin
                    col = col + COLUMN_BITS'(1);
                end
            end
            if (cnt1 && n < LEN_MAX) n = n + LENGTH_BITS'(1);

            // Byte seen between tokens: skip blanks or open a new token.
            if (restart) begin
                mode_next = cst_pkg::M_IDLE;
                if (ws) begin
                    if (isnl) begin
                        if (l < LINE_MAX) l = l + LINE_BITS'(1);
                        col = COLUMN_BITS'(1);
                    end else if (col < COL_MAX) begin
                        col = col + COLUMN_BITS'(1);
                    end
                end else begin
                    tline_next = l; tcol_next = col;
                    pre_next = '0;
                    f_float_next = 1'b0; f_zero_next = 1'b0; f_esc_next = 1'b0; f_star_next = 1'b0;
                    dot_line = l; dot_col = col;
                    if (col < COL_MAX) col = col + COLUMN_BITS'(1);
                    n = LENGTH_BITS'(1);
                    if (is_alpha(c) || c == "_") begin
                        pre_next = {32'd0, c}; mode_next = cst_pkg::M_IDENT;
                    end else if (is_digit(c)) begin
                        f_zero_next = (c == "0"); mode_next = cst_pkg::M_INT;
                    end else begin
                        case (c)
                            8'h22: mode_next = cst_pkg::M_STR;
                            8'h27: mode_next = cst_pkg::M_CHR;
                            "/":   mode_next = cst_pkg::M_SLASH;
                            "=", "!", "<", ">": begin
                                pre_next = {32'd0, c}; mode_next = cst_pkg::M_CMP;
                            end
                            default: begin
                                slots[ns] = '{1'b1, cst_pkg::TK_OTHER, 1'b1, 1'b1, 2'd1};
                                if (c == "(") slots[ns].kind = cst_pkg::TK_LPAREN;
                                if (c == ")") slots[ns].kind = cst_pkg::TK_RPAREN;
                                if (c == "{") slots[ns].kind = cst_pkg::TK_LBRACE;
                                if (c == "}") slots[ns].kind = cst_pkg::TK_RBRACE;
                                ns = ns + 2'd1;
                            end
                        endcase
                    end
                end
            end
            // Dot token after a number sits where the dot was.
            if (mode_reg == cst_pkg::M_DOT && !is_digit(c)) begin
                dot_line = line_reg; dot_col = col_reg;
                if (slots[2].valid) begin
                    // Third slot holds the new single-byte token at its own start.
                end
            end
        end
        line_next = l; col_next = col; cnt_next = n;
        push_count = ns;
    end

    // Result items built from the slots; only the dot-after-number case
    // has two current-position slots, and for a text byte the later one uses the new start.
    always_comb begin
        logic [LINE_BITS-1:0]   pl;
        logic [COLUMN_BITS-1:0] pc;
        logic [LENGTH_BITS-1:0] plen;
        for (int i = 0; i < cst_pkg::MAX_RESULTS; i++) begin
            pl = tline_reg; pc = tcol_reg;
            if (slots[i].use_cur) begin
                pl = dot_line; pc = dot_col;
                if (!eoi && mode_reg == cst_pkg::M_DOT && i == 2) begin
                    pl = tline_next; pc = tcol_next;
                end
                if (eoi && slots[i].kind == cst_pkg::TK_OTHER) begin
                    pl = line_reg; pc = col_reg;
                end
            end
            plen = slots[i].len_fix ? LENGTH_BITS'(slots[i].fixed_len) : cnt_reg;
            if (slots[i].use_cur && slots[i].len_fix && slots[i].kind != cst_pkg::TK_END &&
                !slots[i].use_cur) plen = cnt_reg;
            if (!slots[i].len_fix && slots[i].valid &&
                (mode_reg == cst_pkg::M_STR || mode_reg == cst_pkg::M_CHR) && !eoi)
                plen = cnt_next;
            push_item[i].token_kind   = slots[i].kind;
            push_item[i].start_line   = 24'(pl);
            push_item[i].start_column = 16'(pc);
            push_item[i].token_length = 16'(plen);
            push_item[i].last_of_run  = (2'(i + 1) == push_count);
        end
    end

    // Scanner state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= cst_pkg::M_IDLE;
            line_reg <= LINE_BITS'(1);   col_reg  <= COLUMN_BITS'(1);
            tline_reg <= LINE_BITS'(1);  tcol_reg <= COLUMN_BITS'(1);
            cnt_reg <= '0; pre_reg <= '0;
            f_float_reg <= 1'b0; f_zero_reg <= 1'b0; f_esc_reg <= 1'b0; f_star_reg <= 1'b0;
        end else if (accept) begin
            mode_reg <= mode_next;
            line_reg <= line_next;   col_reg  <= col_next;
            tline_reg <= tline_next; tcol_reg <= tcol_next;
            cnt_reg <= cnt_next; pre_reg <= pre_next;
            f_float_reg <= f_float_next; f_zero_reg <= f_zero_next;
            f_esc_reg <= f_esc_next; f_star_reg <= f_star_next;
        end
    end

    cst_out_queue #(.DEPTH(8)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (accept),
        .push_count (push_count),
        .push_item  (push_item),
        .has_room   (has_room),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_data)
    );

    // An end mark always produces at least the end token.
    a_end_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && eoi |-> push_count != 2'd0) else $error("end mark gave no result");
    // An end mark brings the scanner back to the start position.
    a_end_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && eoi |=> line_reg == LINE_BITS'(1) && col_reg == COLUMN_BITS'(1))
        else $error("end mark did not reset position");
    // Input is refused whenever the queue lacks room for a full burst.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !has_room |-> !s_ready) else $error("input taken without queue room");

endmodule

@@ rtl/cst_out_queue.sv @@
// Output queue that spreads up to three results of one item over the result channel.
module cst_out_queue #(
    parameter int DEPTH = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    input  logic [1:0]          push_count,
    input  cst_pkg::out_item_t  push_item [cst_pkg::MAX_RESULTS],
    output logic                has_room,
    output logic                m_valid,
    input  logic                m_ready,
    output cst_pkg::out_item_t  m_item
);
    localparam int AW = $clog2(DEPTH);

    cst_pkg::out_item_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg, count_next;
    logic          pop;

    assign pop      = m_valid && m_ready;
    assign m_valid  = (count_reg != '0);
    assign m_item   = mem[rd_ptr_reg];
    // Room for a full burst of results from one item.
    assign has_room = (count_reg <= (AW+1)'(DEPTH - cst_pkg::MAX_RESULTS));

    always_comb begin
        count_next = count_reg - (AW+1)'(pop);
        if (push_valid) count_next = count_next + (AW+1)'(push_count);
    end

    // Queue storage writes.
    always_ff @(posedge aclk) begin
        if (push_valid) begin
            for (int i = 0; i < cst_pkg::MAX_RESULTS; i++) begin
                if (2'(i) < push_count) mem[wr_ptr_reg + AW'(i)] <= push_item[i];
            end
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_valid) wr_ptr_reg <= wr_ptr_reg + AW'(push_count);
            if (pop) rd_ptr_reg <= rd_ptr_reg + AW'(1);
            count_reg <= count_next;
        end
    end
endmodule

@@ verif/tb_c_subset_token_scanner_core.sv @@
// Self-checking testbench for the C subset token scanner with a built-in token predictor.
`timescale 1ns / 1ps

module tb_c_subset_token_scanner_core;

    localparam int NUM_ITEMS = 230;
    localparam int HOLD_CYCLES = 80;

    typedef struct {
        cst_pkg::in_item_t  item;
        bit                 typed;
        cst_pkg::out_item_t want;
    } stim_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    cst_pkg::in_item_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    cst_pkg::out_item_t m_data;

    stim_row_t          stim_q[$];
    stim_row_t          cur_row;
    cst_pkg::out_item_t token_q[$];
    int                 fail_count = 0;
    int                 bytes_taken = 0;
    int                 cyc = 0;
    bit                 hold_rx = 1'b0;
    int                 emitted;

    // Scanner state tracked by the predictor.
    cst_pkg::scan_mode_t mode;
    logic [23:0] cur_line, tok_line;
    logic [15:0] cur_col, tok_col, tok_len;
    logic [39:0] kw;
    logic        f_float, f_zero, f_esc, f_star;

    c_subset_token_scanner_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ---------------- Token predictor ----------------

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_xdigit(logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic bit is_suffix(logic [7:0] c);
        return c == "u" || c == "U" || c == "l" || c == "L" || c == "f" || c == "F";
    endfunction

    function automatic cst_pkg::token_kind_t cmp_kind(logic [7:0] ch, bit dbl);
        case (ch)
            "=": return dbl ? cst_pkg::TK_EQ : cst_pkg::TK_OTHER;
            "!": return dbl ? cst_pkg::TK_NE : cst_pkg::TK_OTHER;
            "<": return dbl ? cst_pkg::TK_LE : cst_pkg::TK_LT;
            default: return dbl ? cst_pkg::TK_GE : cst_pkg::TK_GT;
        endcase
    endfunction

    task automatic clear_scanner();
        mode = cst_pkg::M_IDLE;
        cur_line = 24'd1;
        cur_col = 16'd1;
        tok_line = 24'd1;
        tok_col = 16'd1;
        tok_len = '0;
        kw = '0;
        {f_float, f_zero, f_esc, f_star} = '0;
    endtask

    task automatic advance(logic [7:0] c);
        if (c == 8'h0A) begin
            if (cur_line != '1) cur_line++;
            cur_col = 16'd1;
        end else if (cur_col != '1) begin
            cur_col++;
        end
    endtask

    task automatic count_one();
        if (tok_len != '1) tok_len++;
    endtask

    task automatic take(logic [7:0] c);
        advance(c);
        count_one();
    endtask

    task automatic take_suffix(logic [7:0] c);
        if (c == "f" || c == "F") f_float = 1'b1;
        take(c);
    endtask

    task automatic push_token(cst_pkg::token_kind_t kind, logic [15:0] len);
        cst_pkg::out_item_t t;
        if (emitted >= cst_pkg::MAX_RESULTS) return;
        t.token_kind = kind;
        t.start_line = tok_line;
        t.start_column = tok_col;
        t.token_length = len;
        t.last_of_run = 1'b0;
        token_q = {token_q, t};
        emitted++;
    endtask

    task automatic push_ident();
        cst_pkg::token_kind_t k;
        k = cst_pkg::TK_IDENT;
        if (tok_len == 2 && kw == 40'h6966) k = cst_pkg::TK_IF;
        else if (tok_len == 5 && kw == 40'h7768696C65) k = cst_pkg::TK_WHILE;
        push_token(k, tok_len);
    endtask

    task automatic push_number();
        push_token(f_float ? cst_pkg::TK_FLOAT : cst_pkg::TK_INT, tok_len);
    endtask

    task automatic push_dot();
        tok_line = cur_line;
        tok_col = cur_col;
        push_token(cst_pkg::TK_OTHER, 16'd1);
        advance(".");
    endtask

    // One source byte through the scanner.
    task automatic scan_byte(logic [7:0] c);
        logic z;
        case (mode)
            cst_pkg::M_IDENT: begin
                if (is_alpha(c) || is_digit(c) || c == "_") begin
                    take(c);
                    kw = {kw[31:0], c};
                    return;
                end
                push_ident();
            end
            cst_pkg::M_INT: begin
                z = f_zero;
                f_zero = 1'b0;
                if (z && (c == "x" || c == "X")) begin
                    take(c); mode = cst_pkg::M_HEX; return;
                end
                if (is_digit(c)) begin take(c); return; end
                if (c == ".") begin mode = cst_pkg::M_DOT; return; end
                if (c == "e" || c == "E") begin
                    take(c); f_float = 1'b1; mode = cst_pkg::M_EXPS; return;
                end
                if (is_suffix(c)) begin take_suffix(c); mode = cst_pkg::M_SUF; return; end
                push_number();
            end
            cst_pkg::M_DOT: begin
                if (is_digit(c)) begin
                    advance(".");
                    count_one();
                    f_float = 1'b1;
                    take(c);
                    mode = cst_pkg::M_FRAC;
                    return;
                end
                push_number();
                push_dot();
            end
            cst_pkg::M_FRAC: begin
                if (is_digit(c)) begin take(c); return; end
                if (c == "e" || c == "E") begin
                    take(c); f_float = 1'b1; mode = cst_pkg::M_EXPS; return;
                end
                if (is_suffix(c)) begin take_suffix(c); mode = cst_pkg::M_SUF; return; end
                push_number();
            end
            cst_pkg::M_EXPS: begin
                if (c == "+" || c == "-" || is_digit(c)) begin
                    take(c); mode = cst_pkg::M_EXP; return;
                end
                if (is_suffix(c)) begin take_suffix(c); mode = cst_pkg::M_SUF; return; end
                push_number();
            end
            cst_pkg::M_EXP: begin
                if (is_digit(c)) begin take(c); return; end
                if (is_suffix(c)) begin take_suffix(c); mode = cst_pkg::M_SUF; return; end
                push_number();
            end
            cst_pkg::M_HEX: begin
                if (is_xdigit(c)) begin take(c); return; end
                if (is_suffix(c)) begin take_suffix(c); mode = cst_pkg::M_SUF; return; end
                push_number();
            end
            cst_pkg::M_SUF: begin
                if (is_suffix(c)) begin take_suffix(c); return; end
                push_number();
            end
            cst_pkg::M_STR, cst_pkg::M_CHR: begin
                if (f_esc) begin f_esc = 1'b0; take(c); return; end
                if (c == ((mode == cst_pkg::M_STR) ? 8'h22 : 8'h27)) begin
                    take(c);
                    push_token((mode == cst_pkg::M_STR) ? cst_pkg::TK_STRING : cst_pkg::TK_CHAR,
                               tok_len);
                    mode = cst_pkg::M_IDLE;
                    return;
                end
                if (c == 8'h5C) f_esc = 1'b1;
                take(c);
                return;
            end
            cst_pkg::M_SLASH: begin
                if (c == "/") begin advance(c); mode = cst_pkg::M_LINEC; return; end
                if (c == "*") begin
                    advance(c); f_star = 1'b0; mode = cst_pkg::M_BLOCK; return;
                end
                push_token(cst_pkg::TK_OTHER, 16'd1);
            end
            cst_pkg::M_LINEC: begin
                if (c != 8'h0A) begin advance(c); return; end
            end
            cst_pkg::M_BLOCK: begin
                if (f_star && c == "/") begin
                    advance(c);
                    {f_float, f_zero, f_esc, f_star} = '0;
                    mode = cst_pkg::M_IDLE;
                    return;
                end
                f_star = (c == "*");
                advance(c);
                return;
            end
            cst_pkg::M_CMP: begin
                if (c == "=") begin
                    take(c);
                    push_token(cmp_kind(kw[7:0], 1'b1), 16'd2);
                    mode = cst_pkg::M_IDLE;
                    return;
                end
                push_token(cmp_kind(kw[7:0], 1'b0), 16'd1);
            end
            default: ;
        endcase

        // Between tokens: skip blanks or open a new token.
        mode = cst_pkg::M_IDLE;
        if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin
            advance(c);
            return;
        end
        tok_line = cur_line;
        tok_col = cur_col;
        tok_len = '0;
        kw = '0;
        {f_float, f_zero, f_esc, f_star} = '0;
        take(c);
        if (is_alpha(c) || c == "_") begin kw = {32'd0, c}; mode = cst_pkg::M_IDENT; return; end
        if (is_digit(c)) begin f_zero = (c == "0"); mode = cst_pkg::M_INT; return; end
        case (c)
            8'h22: mode = cst_pkg::M_STR;
            8'h27: mode = cst_pkg::M_CHR;
            "/": mode = cst_pkg::M_SLASH;
            "(": push_token(cst_pkg::TK_LPAREN, 16'd1);
            ")": push_token(cst_pkg::TK_RPAREN, 16'd1);
            "{": push_token(cst_pkg::TK_LBRACE, 16'd1);
            "}": push_token(cst_pkg::TK_RBRACE, 16'd1);
            "=", "!", "<", ">": begin kw = {32'd0, c}; mode = cst_pkg::M_CMP; end
            default: push_token(cst_pkg::TK_OTHER, 16'd1);
        endcase
    endtask

    // End mark: flush the pending token, emit the end token, start over.
    task automatic scan_end();
        case (mode)
            cst_pkg::M_IDENT: push_ident();
            cst_pkg::M_INT, cst_pkg::M_FRAC, cst_pkg::M_EXPS, cst_pkg::M_EXP,
            cst_pkg::M_HEX, cst_pkg::M_SUF: push_number();
            cst_pkg::M_DOT: begin push_number(); push_dot(); end
            cst_pkg::M_STR: push_token(cst_pkg::TK_STRING, tok_len);
            cst_pkg::M_CHR: push_token(cst_pkg::TK_CHAR, tok_len);
            cst_pkg::M_SLASH: push_token(cst_pkg::TK_OTHER, 16'd1);
            cst_pkg::M_CMP: push_token(cmp_kind(kw[7:0], 1'b0), 16'd1);
            default: ;
        endcase
        tok_line = cur_line;
        tok_col = cur_col;
        push_token(cst_pkg::TK_END, 16'd0);
        clear_scanner();
    endtask

    task automatic predict_tokens(stim_row_t row);
        int base;
        base = token_q.size();
        emitted = 0;
        if (row.item.end_of_input) scan_end();
        else scan_byte(row.item.text_byte);
        // Rows with a typed expectation replace what the predictor produced.
        if (row.typed) begin
            while (token_q.size() > base) void'(token_q.pop_back());
            token_q = {token_q, row.want};
        end else if (token_q.size() > base) begin
            token_q[token_q.size() - 1].last_of_run = 1'b1;
        end
    endtask

    // ---------------- Stimulus ----------------

    task automatic add_byte(logic [7:0] c);
        stim_row_t r;
        r.item.text_byte = c;
        r.item.end_of_input = 1'b0;
        r.typed = 1'b0;
        r.want = '0;
        stim_q = {stim_q, r};
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    task automatic add_end();
        stim_row_t r;
        r.item.text_byte = 8'($urandom_range(255));
        r.item.end_of_input = 1'b1;
        r.typed = 1'b0;
        r.want = '0;
        stim_q = {stim_q, r};
    endtask

    task automatic add_typed(logic [7:0] c, logic eoi, cst_pkg::token_kind_t k, int line,
                             int col, int len);
        stim_row_t r;
        r.item.text_byte = c;
        r.item.end_of_input = eoi;
        r.typed = 1'b1;
        r.want.token_kind = k;
        r.want.start_line = 24'(line);
        r.want.start_column = 16'(col);
        r.want.token_length = 16'(len);
        r.want.last_of_run = 1'b1;
        stim_q = {stim_q, r};
    endtask

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    // One fragment with random content, mostly well-formed, or noise now and then.
    task automatic add_fragment();
        int n;
        case ($urandom_range(13))
            0: add_text($urandom_range(1) ? "if" : "while");
            1: begin
                add_byte(pick("abcXYZ_q"));
                n = $urandom_range(5);
                repeat (n) add_byte(pick("ifwhle_09Z"));
            end
            2: begin
                add_text($urandom_range(1) ? "0x" : "0X");
                repeat ($urandom_range(4)) add_byte(pick("09afAF"));
            end
            3: begin
                add_byte(pick("0123456789"));
                repeat ($urandom_range(2)) add_byte(pick("0789"));
                if ($urandom_range(1)) add_byte(".");
                repeat ($urandom_range(2)) add_byte(pick("135"));
                if ($urandom_range(1)) begin
                    add_byte(pick("eE"));
                    if ($urandom_range(1)) add_byte(pick("+-"));
                    repeat ($urandom_range(2)) add_byte(pick("29"));
                end
                repeat ($urandom_range(2)) add_byte(pick("uUlLfF"));
            end
            4, 5: begin
                add_byte(($urandom_range(1)) ? 8'h22 : 8'h27);
                repeat ($urandom_range(4)) add_byte(pick("a\\\"' z"));
                if ($urandom_range(3) != 0) add_byte(pick("\"'"));
            end
            6: begin
                add_byte(pick("=!<>"));
                if ($urandom_range(1)) add_byte("=");
            end
            7: add_byte(pick("(){}"));
            8: begin
                add_text("//");
                repeat ($urandom_range(3)) add_byte(pick("a */"));
                add_byte(8'h0A);
            end
            9: begin
                add_text("/*");
                repeat ($urandom_range(4)) add_byte(pick("*x/\n"));
                if ($urandom_range(3) != 0) add_text("*/");
            end
            10: add_byte(pick(" \t\r\n/"));
            11: add_byte(8'($urandom_range(255)));
            12: add_byte(($urandom_range(1)) ? 8'h00 : 8'($urandom_range(128, 255)));
            default: if ($urandom_range(3) == 0) add_end(); else add_byte(" ");
        endcase
    endtask

    initial begin
        // Trivial tokens and the end token, with and without the top and bottom byte.
        add_typed("(", 1'b0, cst_pkg::TK_LPAREN, 1, 1, 1);
        add_typed(")", 1'b0, cst_pkg::TK_RPAREN, 1, 2, 1);
        add_typed(8'hFF, 1'b1, cst_pkg::TK_END, 1, 3, 0);
        add_typed(8'h00, 1'b0, cst_pkg::TK_OTHER, 1, 1, 1);
        add_typed(8'hFF, 1'b0, cst_pkg::TK_OTHER, 1, 2, 1);
        add_typed(8'h00, 1'b1, cst_pkg::TK_END, 1, 3, 0);
        // Keyword, comparison, suffixed hex, dot before exponent, open string.
        add_text("while!=0xFu 5.e3f\"\\");
        add_end();
        while (stim_q.size() < NUM_ITEMS) add_fragment();
        add_end();
    end

    // ---------------- Reset and input driver ----------------

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) cyc <= cyc + 1;

    function automatic bit idle_now();
        if (cyc >= 180 && cyc < 280) return 1'b0;
        return $urandom_range(99) < 31;
    endfunction

    always @(posedge aclk) begin
        logic next_valid;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            next_valid = s_valid;
            if (s_valid && s_ready) begin
                predict_tokens(cur_row);
                bytes_taken <= bytes_taken + 1;
                next_valid = 1'b0;
            end
            if (!next_valid && stim_q.size() > 0 && !idle_now()) begin
                cur_row = stim_q.pop_front();
                s_data <= cur_row.item;
                next_valid = 1'b1;
            end
            s_valid <= next_valid;
        end
    end

    initial clear_scanner();

    // ---------------- Result side ----------------

    // Long hold-off so the result queue fills and the input stalls.
    initial begin
        wait (bytes_taken >= 60);
        @(posedge aclk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_rx <= 1'b0;
    end

    always @(posedge aclk) begin
        cst_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (token_q.size() == 0) begin
                $error("unexpected token transfer: kind %0d", m_data.token_kind);
                fail_count++;
            end else begin
                want = token_q.pop_front();
                if (m_data.token_kind !== want.token_kind) begin
                    $error("token_kind: expected %0d, got %0d", want.token_kind,
                           m_data.token_kind);
                    fail_count++;
                end
                if (m_data.start_line !== want.start_line) begin
                    $error("start_line: expected %0d, got %0d", want.start_line,
                           m_data.start_line);
                    fail_count++;
                end
                if (m_data.start_column !== want.start_column) begin
                    $error("start_column: expected %0d, got %0d", want.start_column,
                           m_data.start_column);
                    fail_count++;
                end
                if (m_data.token_length !== want.token_length) begin
                    $error("token_length: expected %0d, got %0d", want.token_length,
                           m_data.token_length);
                    fail_count++;
                end
                if (m_data.last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                           m_data.last_of_run);
                    fail_count++;
                end
            end
        end
        m_ready <= aresetn && !hold_rx && !idle_now();
    end

    // ---------------- End of run ----------------

    initial begin
        wait (aresetn === 1'b1);
        @(posedge aclk);
        while (stim_q.size() > 0 || s_valid || token_q.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (token_q.size() > 0) begin
            $error("%0d tokens never arrived", token_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #(12 * 200000);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
